/* rtl/rxswc_pkg.sv */
// ----------------------------------------------------------------------------
// rxswc_pkg
// Shared types and constants for the receive sequence window checker.
// ----------------------------------------------------------------------------
package rxswc_pkg;

    localparam int DEF_SEQ_WIDTH = 32;

    localparam int WIN_W     = 31;
    localparam int RUN_W     = 8;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    localparam logic [WIN_W-1:0] SKIP_WINDOW_RST = WIN_W'(16);
    localparam logic [WIN_W-1:0] BIG_WINDOW_RST  = WIN_W'(1024);
    localparam logic [RUN_W-1:0] BIG_RUN_RST     = RUN_W'(3);

    // register indexes on the config channel
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_WINDOW    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_WINDOW     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_WINDOW_RUN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_START_SEQUENCE = CFG_IDX_W'(3);

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SKIP    = 3'd1,
        ST_BIG     = 3'd2,
        ST_PENDING = 3'd3,
        ST_REPLAY  = 3'd4
    } t_status;

    typedef struct packed {
        logic [WIN_W-1:0] skip_window;
        logic [WIN_W-1:0] big_window;
        logic [RUN_W-1:0] big_window_run;
    } t_cfg;

endpackage

/* rtl/rxswc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// rxswc_cfg_regs
// Window configuration registers and start-sequence load strobe.
// ----------------------------------------------------------------------------
module rxswc_cfg_regs
    import rxswc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                 o_cfg,
    output logic                 o_load
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.skip_window    <= SKIP_WINDOW_RST;
            r_cfg.big_window     <= BIG_WINDOW_RST;
            r_cfg.big_window_run <= BIG_RUN_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_SKIP_WINDOW) begin
                r_cfg.skip_window <= i_cfg_data[WIN_W-1:0];
            end
            if (i_cfg_index == CFG_BIG_WINDOW) begin
                r_cfg.big_window <= i_cfg_data[WIN_W-1:0];
            end
            if (i_cfg_index == CFG_BIG_WINDOW_RUN) begin
                r_cfg.big_window_run <= i_cfg_data[RUN_W-1:0];
            end
        end
    end

    assign o_cfg  = r_cfg;
    assign o_load = i_cfg_valid && (i_cfg_index == CFG_START_SEQUENCE);

endmodule

/* rtl/rxswc_classify.sv */
// ----------------------------------------------------------------------------
// rxswc_classify
// Classifies one sequence number against the window state and computes
// the next window state.
// ----------------------------------------------------------------------------
module rxswc_classify
    import rxswc_pkg::*;
#(
    parameter int SEQ_WIDTH = DEF_SEQ_WIDTH
) (
    input  t_cfg                 i_cfg,
    input  logic [SEQ_WIDTH-1:0] i_seq,
    input  logic [SEQ_WIDTH-1:0] i_expected,
    input  logic                 i_active,
    input  logic [SEQ_WIDTH-1:0] i_tracked,
    input  logic [RUN_W-1:0]     i_run,
    output t_status              o_status,
    output logic [SEQ_WIDTH-1:0] o_expected,
    output logic                 o_active,
    output logic [SEQ_WIDTH-1:0] o_tracked,
    output logic [RUN_W-1:0]     o_run
);

    localparam int CMP_W = (SEQ_WIDTH > WIN_W) ? SEQ_WIDTH : WIN_W;

    logic [SEQ_WIDTH-1:0] w_dist;
    logic [SEQ_WIDTH-1:0] w_seq_inc;
    logic [CMP_W-1:0]     w_dist_x;
    logic                 w_lt_skip;
    logic                 w_lt_big;
    logic                 w_bk_active;
    logic [SEQ_WIDTH-1:0] w_bk_tracked;
    logic [RUN_W-1:0]     w_bk_run;

    assign w_dist    = i_seq - i_expected;
    assign w_seq_inc = i_seq + SEQ_WIDTH'(1);
    assign w_dist_x  = CMP_W'(w_dist);
    assign w_lt_skip = w_dist_x < CMP_W'(i_cfg.skip_window);
    assign w_lt_big  = w_dist_x < CMP_W'(i_cfg.big_window);

    // big-window run tracker
    always_comb begin
        w_bk_active  = i_active;
        w_bk_tracked = i_tracked;
        w_bk_run     = i_run;
        priority if (!i_active) begin
            w_bk_active  = 1'b1;
            w_bk_tracked = w_seq_inc;
            w_bk_run     = '0;
        end else if (i_seq == i_tracked) begin
            w_bk_tracked = i_tracked + SEQ_WIDTH'(1);
            w_bk_run     = i_run + RUN_W'(1);
        end else begin
            w_bk_active = 1'b0;
        end
    end

    always_comb begin
        o_status   = ST_OK;
        o_expected = i_expected;
        o_active   = i_active;
        o_tracked  = i_tracked;
        o_run      = i_run;
        priority if (w_dist == '0) begin
            o_status   = ST_OK;
            o_expected = w_seq_inc;
            o_active   = 1'b0;
        end else if (w_lt_skip) begin
            o_status   = ST_SKIP;
            o_expected = w_seq_inc;
            o_active   = 1'b0;
        end else if (w_lt_big) begin
            o_tracked = w_bk_tracked;
            o_run     = w_bk_run;
            if (w_bk_run == i_cfg.big_window_run) begin
                o_status   = ST_BIG;
                o_expected = w_seq_inc;
                o_active   = 1'b0;
            end else begin
                o_status = ST_PENDING;
                o_active = w_bk_active;
            end
        end else if (i_seq < i_expected) begin
            o_status = ST_REPLAY;
        end else begin
            // far ahead of both windows: plain ok, step by one
            o_status   = ST_OK;
            o_expected = i_expected + SEQ_WIDTH'(1);
            o_active   = 1'b0;
        end
    end

endmodule

/* rtl/rx_sequence_window_check_core.sv */
// Path: each input transaction passes through the input register, then the
// result register, before its result is valid on the result stream.
// Throughput: one transaction per cycle unless the result stream stalls. The
// window state is updated as each item leaves, before the next is checked.
// Reset (synchronous, active low) empties both stages, loads expected
// sequence 0, clears tracking and restores the default windows.
// ----------------------------------------------------------------------------
// rx_sequence_window_check_core
// Receive anti-replay sequence check with skip-window and run-confirmed
// big-window resync.
// ----------------------------------------------------------------------------
module rx_sequence_window_check_core
    import rxswc_pkg::*;
#(
    parameter int SEQ_WIDTH = DEF_SEQ_WIDTH,
    localparam int IN_TW    = ((SEQ_WIDTH + 7) / 8) * 8,
    localparam int OUT_TW   = ((SEQ_WIDTH + 3 + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IN_TW-1:0]     i_s_tdata,   // [SEQ_WIDTH-1:0] sequence_req
    // result stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OUT_TW-1:0]    o_m_tdata,   // [2:0] status,
                                              // [SEQ_WIDTH+2:3] next_expected
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // config
    t_cfg w_cfg;
    logic w_load;

    // input stage
    logic                 r_in_valid;
    logic [SEQ_WIDTH-1:0] r_in_seq;

    // window state
    logic [SEQ_WIDTH-1:0] r_expected;
    logic                 r_active;
    logic [SEQ_WIDTH-1:0] r_tracked;
    logic [RUN_W-1:0]     r_run;

    // classifier outputs
    t_status              n_status;
    logic [SEQ_WIDTH-1:0] n_expected;
    logic                 n_active;
    logic [SEQ_WIDTH-1:0] n_tracked;
    logic [RUN_W-1:0]     n_run;

    // result stage
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [SEQ_WIDTH-1:0] r_out_expected;

    logic w_out_free;
    logic w_advance;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    rxswc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg),
        .o_load      (w_load)
    );

    // Handshake: the result register frees up when empty or being drained;
    // the input register moves into it whenever it is free.
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_seq <= i_s_tdata[SEQ_WIDTH-1:0];
        end
    end

    rxswc_classify #(
        .SEQ_WIDTH (SEQ_WIDTH)
    ) u_classify (
        .i_cfg      (w_cfg),
        .i_seq      (r_in_seq),
        .i_expected (r_expected),
        .i_active   (r_active),
        .i_tracked  (r_tracked),
        .i_run      (r_run),
        .o_status   (n_status),
        .o_expected (n_expected),
        .o_active   (n_active),
        .o_tracked  (n_tracked),
        .o_run      (n_run)
    );

    // Window state. A start_sequence write reloads expected and clears the
    // tracker; otherwise state follows each item as it enters the result reg.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= '0;
            r_active   <= 1'b0;
            r_tracked  <= '0;
            r_run      <= '0;
        end else if (w_load) begin
            r_expected <= SEQ_WIDTH'(i_cfg_data);
            r_active   <= 1'b0;
            r_tracked  <= '0;
            r_run      <= '0;
        end else if (w_advance) begin
            r_expected <= n_expected;
            r_active   <= n_active;
            r_tracked  <= n_tracked;
            r_run      <= n_run;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_status   <= n_status;
            r_out_expected <= n_expected;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TW'({r_out_expected, r_out_status});

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // reset empties the result stage
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // pending and replay leave the expected sequence alone
    a_hold_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !w_load && (n_status == ST_PENDING || n_status == ST_REPLAY))
        |=> (r_expected == $past(r_expected)))
        else $error("expected sequence moved on pending/replay");

    // any accepted frame cancels big-window tracking
    a_accept_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !w_load && (n_status == ST_OK || n_status == ST_SKIP ||
                                  n_status == ST_BIG))
        |=> !r_active)
        else $error("tracking still active after accept");

    // the reported next_expected is the state the next item sees
    a_report_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !w_load) |=> (r_out_expected == r_expected))
        else $error("reported next_expected differs from state");

endmodule
